// ===== design/bst_pkg.sv =====
// Shared types, constants and helpers for the bucketed slot table.
`default_nettype none

package bst_pkg;

  localparam int SLOTS       = 64;
  localparam int BUCKET_SIZE = 100;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int BKT_W  = 16;
  localparam int DIST_W = 13;
  localparam int SITE_W = 32;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_HAS  = 2'd1,
    OP_FIND = 2'd2,
    OP_LIST = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_RANGE = 2'd1,
    ST_NOT_FOUND    = 2'd2,
    ST_EMPTY_RANGE  = 2'd3
  } status_e;

  // one slot as it travels along the ring
  typedef struct packed {
    logic   valid;
    value_t value;
  } slot_t;

  typedef struct packed {
    logic   advance;
    logic   write;
    value_t wr_value;
  } ring_ctrl_t;

  function automatic value_t site_to_value(logic [SITE_W-1:0] s);
    value_t v;
    v = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i < SITE_W) v[i] = s[i];
    end
    return v;
  endfunction

  function automatic logic [SITE_W-1:0] value_to_site(value_t v);
    logic [SITE_W-1:0] s;
    s = '0;
    for (int i = 0; i < SITE_W; i++) begin
      if (i < VALUE_BITS) s[i] = v[i];
    end
    return s;
  endfunction

  function automatic logic [DIST_W-1:0] dist_of(logic [IDX_W-1:0] idx);
    logic [31:0] prod;
    prod = 32'(idx) * 32'(BUCKET_SIZE);
    return prod[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/bst_cell.sv =====
// One slot of the ring: holds a value and its valid bit, takes its neighbor's on advance.
`default_nettype none

module bst_cell
  import bst_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  advance_i,
  input  wire slot_t slot_i,
  output slot_t      slot_o
);

  logic   valid_q;
  value_t value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      value_q <= slot_i.value;
    end
  end

  assign slot_o = '{valid: valid_q, value: value_q};

endmodule

`default_nettype wire

// ===== design/bst_ring.sv =====
// Circular chain of slot cells; cell 0 is the head, the head re-enters at the tail.
`default_nettype none

module bst_ring
  import bst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ring_ctrl_t ctrl_i,
  output slot_t           head_o
);

  slot_t cells [SLOTS];
  slot_t tail;

  // head either comes back around unchanged or is replaced by a write
  always_comb begin
    tail = cells[0];
    if (ctrl_i.write) begin
      tail = '{valid: 1'b1, value: ctrl_i.wr_value};
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == SLOTS - 1) begin : g_tail
      bst_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .advance_i (ctrl_i.advance),
        .slot_i    (tail),
        .slot_o    (cells[g])
      );
    end else begin : g_mid
      bst_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .advance_i (ctrl_i.advance),
        .slot_i    (cells[g+1]),
        .slot_o    (cells[g])
      );
    end
  end

  assign head_o = cells[0];

endmodule

`default_nettype wire

// ===== design/bucketed_slot_table_unit.sv =====
// Top level of the bucketed slot table: request decode, ring sweep control, result register.
// Every request rotates the slot ring once, sweeping all SLOTS slots past the head, and
// then loads its final result from the done state; one request at a time.
// The ring sets the sweep length: it shows one slot per cycle at its head when not paused.
// A list request pauses the ring while a hit waits to go out and the result register stalls.
// Reset (async, active low) clears all valid bits, the occupied count and the control state.
`default_nettype none

module bucketed_slot_table_unit
  import bst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] meters_i,
  input  wire logic [15:0] meters_to_i,
  input  wire logic [31:0] site_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             present_o,
  output logic [12:0]      bucket_distance_o,
  output logic [31:0]      site_value_o,
  output logic [6:0]       occupied_count_o,
  output logic             last_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  localparam logic [BKT_W-1:0] SlotsB   = BKT_W'(SLOTS);
  localparam logic [BKT_W-1:0] LastB    = BKT_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(SLOTS - 1);

  // bucket = (meters * ceil(2^26 / BUCKET_SIZE)) >> 26, exact for 16-bit distances
  localparam int DivShift = 26;
  localparam int DivProdW = BKT_W + DivShift;
  localparam logic [DivProdW-1:0] DivRecip =
    DivProdW'(((longint'(1) << DivShift) + BUCKET_SIZE - 1) / BUCKET_SIZE);

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  op_e               op_q;
  logic [BKT_W-1:0]  from_q, to_q;
  value_t            site_q;
  logic              oor_q;
  logic              flag_q, flag_d;      // has answer, find hit, list held
  logic [DIST_W-1:0] held_dist_q, held_dist_d;
  logic [SITE_W-1:0] held_val_q, held_val_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_st_q, out_st_d;
  logic              out_pres_q, out_pres_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic [SITE_W-1:0] out_val_q, out_val_d;
  logic              out_last_q, out_last_d;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_load;

  ring_ctrl_t        ring_ctrl;
  slot_t             head;

  logic              accept, can_push, idx_hit, in_rng, need_emit;
  logic [BKT_W-1:0]  idx_b, from_b, to_b;
  logic [DivProdW-1:0] from_prod, to_prod;

  bst_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .head_o (head)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_push   = !out_valid_q || !out_stall_i;

  assign from_prod = DivProdW'(meters_i) * DivRecip;
  assign to_prod   = DivProdW'(meters_to_i) * DivRecip;
  assign from_b    = from_prod[DivShift +: BKT_W];
  assign to_b      = to_prod[DivShift +: BKT_W];
  assign idx_b   = BKT_W'(idx_q);
  assign idx_hit = (idx_b == from_q);
  assign in_rng  = (op_q == OP_LIST) && (idx_b >= from_q) && (idx_b <= to_q);
  // a list hit can only move on once the previously held hit has gone out
  assign need_emit = in_rng && head.valid && flag_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    flag_d      = flag_q;
    held_dist_d = held_dist_q;
    held_val_d  = held_val_q;
    ring_ctrl   = '{advance: 1'b0, write: 1'b0, wr_value: site_q};
    out_load    = 1'b0;
    out_st_d    = ST_OK;
    out_pres_d  = 1'b0;
    out_dist_d  = '0;
    out_val_d   = '0;
    out_last_d  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SWEEP;
          idx_d   = '0;
          flag_d  = 1'b0;
        end
      end
      S_SWEEP: begin
        if (!need_emit || can_push) begin
          ring_ctrl.advance = 1'b1;
          case (op_q)
            OP_ADD: begin
              if (idx_hit) begin
                ring_ctrl.write = 1'b1;
                if (!head.valid) count_d = count_q + 1'b1;
              end
            end
            OP_HAS: begin
              if (idx_hit) flag_d = head.valid;
            end
            OP_FIND: begin
              if (!flag_q && head.valid && head.value == site_q) begin
                flag_d      = 1'b1;
                held_dist_d = dist_of(idx_q);
              end
            end
            OP_LIST: begin
              if (in_rng && head.valid) begin
                if (flag_q) begin
                  out_load   = 1'b1;
                  out_pres_d = 1'b1;
                  out_dist_d = held_dist_q;
                  out_val_d  = held_val_q;
                end
                flag_d      = 1'b1;
                held_dist_d = dist_of(idx_q);
                held_val_d  = value_to_site(head.value);
              end
            end
            default: ;
          endcase
          if (idx_q == LastIdx) begin
            state_d = S_DONE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (can_push) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
          case (op_q)
            OP_ADD: begin
              out_st_d   = oor_q ? ST_OUT_OF_RANGE : ST_OK;
              out_pres_d = !oor_q;
            end
            OP_HAS: begin
              out_st_d   = oor_q ? ST_OUT_OF_RANGE : ST_OK;
              out_pres_d = !oor_q && flag_q;
            end
            OP_FIND: begin
              out_st_d   = flag_q ? ST_OK : ST_NOT_FOUND;
              out_pres_d = flag_q;
              out_dist_d = flag_q ? held_dist_q : '0;
            end
            OP_LIST: begin
              out_st_d   = flag_q ? ST_OK : ST_EMPTY_RANGE;
              out_pres_d = flag_q;
              out_dist_d = flag_q ? held_dist_q : '0;
              out_val_d  = flag_q ? held_val_q : '0;
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_dist_q <= held_dist_d;
    held_val_q  <= held_val_d;
    if (accept) begin
      op_q   <= op_e'(op_i);
      from_q <= from_b;
      to_q   <= (to_b >= SlotsB) ? LastB : to_b;
      site_q <= site_to_value(site_i);
      oor_q  <= (from_b >= SlotsB);
    end
    if (out_load) begin
      out_st_q   <= out_st_d;
      out_pres_q <= out_pres_d;
      out_dist_q <= out_dist_d;
      out_val_q  <= out_val_d;
      out_last_q <= out_last_d;
      out_cnt_q  <= count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_st_q;
  assign present_o         = out_pres_q;
  assign bucket_distance_o = out_dist_q;
  assign site_value_o      = out_val_q;
  assign occupied_count_o  = 7'(out_cnt_q);
  assign last_o            = out_last_q;

endmodule

`default_nettype wire

// ===== tb/bucketed_slot_table_unit_test.sv =====
// Self-checking bench for the bucketed slot table: directed and random requests against a shadow table.
module bucketed_slot_table_unit_test;
  import bst_pkg::*;

  localparam int LONG_HOLD    = 400;
  // worst case: every request listing all slots, each result behind a long stall, several times over
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int BATCH        = 100;

  typedef enum int {GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} gap_mode_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] meters;
    logic [15:0] meters_to;
    logic [31:0] site;
    logic        drain_first;
  } table_req_t;

  typedef struct packed {
    status_e     status;
    logic        present;
    logic [12:0] distance;
    logic [31:0] site_value;
    logic [6:0]  count;
    logic        last;
  } table_answer_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i        = '0;
  logic [15:0] meters_i    = '0;
  logic [15:0] meters_to_i = '0;
  logic [31:0] site_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        present_o;
  logic [12:0] bucket_distance_o;
  logic [31:0] site_value_o;
  logic [6:0]  occupied_count_o;
  logic        last_o;

  bucketed_slot_table_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .meters_i          (meters_i),
    .meters_to_i       (meters_to_i),
    .site_i            (site_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .present_o         (present_o),
    .bucket_distance_o (bucket_distance_o),
    .site_value_o      (site_value_o),
    .occupied_count_o  (occupied_count_o),
    .last_o            (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic [31:0] shadow_site [SLOTS];
  logic        shadow_used [SLOTS];
  logic [6:0]  shadow_count;

  table_req_t    pending_requests[$];
  table_answer_t table_answers[$];
  logic [31:0]   site_pool [8];

  int  queued_count   = 0;
  int  accepted_count = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_kick      = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;
  bit  req_accepted   = 1'b0;

  function automatic void post_answer(status_e st, logic pres, logic [12:0] bdist,
                                      logic [31:0] val, logic lst);
    table_answer_t a;
    a.status     = st;
    a.present    = pres;
    a.distance   = bdist;
    a.site_value = val;
    a.count      = shadow_count;
    a.last       = lst;
    table_answers.push_back(a);
  endfunction

  function automatic void apply_table_request(table_req_t rq);
    int  from_b;
    int  to_b;
    int  hits;
    int  sent;
    bit  found;
    from_b = int'(rq.meters) / BUCKET_SIZE;
    to_b   = int'(rq.meters_to) / BUCKET_SIZE;
    case (rq.op)
      OP_ADD: begin
        if (from_b >= SLOTS) begin
          post_answer(ST_OUT_OF_RANGE, 1'b0, '0, '0, 1'b1);
        end else begin
          if (!shadow_used[from_b]) begin
            shadow_used[from_b] = 1'b1;
            shadow_count++;
          end
          shadow_site[from_b] = rq.site;
          post_answer(ST_OK, 1'b1, '0, '0, 1'b1);
        end
      end
      OP_HAS: begin
        if (from_b >= SLOTS) post_answer(ST_OUT_OF_RANGE, 1'b0, '0, '0, 1'b1);
        else post_answer(ST_OK, shadow_used[from_b], '0, '0, 1'b1);
      end
      OP_FIND: begin
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && shadow_used[i] && shadow_site[i] == rq.site) begin
            found = 1'b1;
            post_answer(ST_OK, 1'b1, 13'(i * BUCKET_SIZE), '0, 1'b1);
          end
        end
        if (!found) post_answer(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
      end
      default: begin
        if (to_b >= SLOTS) to_b = SLOTS - 1;
        hits = 0;
        for (int i = from_b; i <= to_b; i++) begin
          if (shadow_used[i]) hits++;
        end
        sent = 0;
        for (int i = from_b; i <= to_b; i++) begin
          if (shadow_used[i]) begin
            post_answer(ST_OK, 1'b1, 13'(i * BUCKET_SIZE), shadow_site[i], sent == hits - 1);
            sent++;
          end
        end
        if (hits == 0) post_answer(ST_EMPTY_RANGE, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void report_mismatch(string what, table_answer_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch (%s): got status=%0d present=%0d dist=%0d value=%h count=%0d last=%0d",
               what, status_o, present_o, bucket_distance_o, site_value_o,
               occupied_count_o, last_o);
      $display("            want status=%0d present=%0d dist=%0d value=%h count=%0d last=%0d",
               want.status, want.present, want.distance, want.site_value,
               want.count, want.last);
    end
  endfunction

  // monitor: check results first, then predict for a request taken at this edge
  always @(posedge clk_i) begin
    table_answer_t want;
    table_req_t    rq;
    req_accepted = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (table_answers.size() == 0) begin
          want = '0;
          report_mismatch("unexpected result", want);
        end else begin
          want = table_answers.pop_front();
          if (status_o !== want.status || present_o !== want.present ||
              bucket_distance_o !== want.distance || site_value_o !== want.site_value ||
              occupied_count_o !== want.count || last_o !== want.last)
            report_mismatch("field", want);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        rq.op          = op_e'(op_i);
        rq.meters      = meters_i;
        rq.meters_to   = meters_to_i;
        rq.site        = site_i;
        rq.drain_first = 1'b0;
        apply_table_request(rq);
        req_accepted = 1'b1;
        accepted_count++;
      end
    end
  end

  // driver: hold a stalled request, otherwise maybe offer the next one
  always @(negedge clk_i) begin
    table_req_t rq;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_accepted) begin
      if (pending_requests.size() > 0 &&
          !(pending_requests[0].drain_first && table_answers.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        rq = pending_requests.pop_front();
        op_i        <= rq.op;
        meters_i    <= rq.meters;
        meters_to_i <= rq.meters_to;
        site_i      <= rq.site;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, random, with a long hold-off when the test kicks one
  always @(negedge clk_i) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic set_gaps(gap_mode_e m);
    case (m)
      GAPS_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      GAPS_SENDER:   begin send_idle_pct = 64; recv_stall_pct = 0;  end
      GAPS_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default:       begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  task automatic queue_request(op_e op, logic [15:0] m, logic [15:0] mt, logic [31:0] s,
                               logic drain);
    table_req_t rq;
    rq.op          = op;
    rq.meters      = m;
    rq.meters_to   = mt;
    rq.site        = s;
    rq.drain_first = drain;
    pending_requests.push_back(rq);
    queued_count++;
  endtask

  // mostly in-table distances and short list spans; sites mostly drawn from a small pool so finds hit
  function automatic table_req_t random_request();
    table_req_t rq;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) rq.op = OP_ADD;
    else if (pick < 55) rq.op = OP_HAS;
    else if (pick < 75) rq.op = OP_FIND;
    else rq.op = OP_LIST;
    if ($urandom_range(9) == 0) rq.meters = 16'($urandom);
    else rq.meters = 16'($urandom_range(SLOTS * BUCKET_SIZE - 1));
    rq.meters_to = 16'($urandom);
    if (rq.op == OP_LIST) begin
      pick = $urandom_range(19);
      if (pick < 16) begin
        if (rq.meters > 16'd64735) rq.meters_to = 16'hffff;
        else rq.meters_to = rq.meters + 16'($urandom_range(800));
      end else if (pick == 16) begin
        rq.meters    = 16'($urandom_range(99));
        rq.meters_to = 16'hffff;
      end
    end
    if ($urandom_range(9) < 6) rq.site = site_pool[$urandom_range(7)];
    else rq.site = $urandom;
    rq.drain_first = 1'b0;
    return rq;
  endfunction

  initial begin
    table_req_t rq;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_site[i] = '0;
    end
    shadow_count = '0;
    site_pool[0] = '0;
    site_pool[1] = '1;
    for (int k = 2; k < 8; k++) site_pool[k] = $urandom;
    set_gaps(GAPS_NONE);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table first, then edges of the distance range, overwrite, clipping, inverted ranges
    queue_request(OP_HAS,  16'd0,     16'd0,     32'h0,        1'b0);
    queue_request(OP_FIND, 16'd0,     16'd0,     32'h0,        1'b0);
    queue_request(OP_LIST, 16'd0,     16'hffff,  32'h0,        1'b0);
    queue_request(OP_ADD,  16'd0,     16'd0,     32'h0,        1'b0);
    queue_request(OP_ADD,  16'd99,    16'd0,     32'hffffffff, 1'b0);
    queue_request(OP_ADD,  16'd6399,  16'd0,     32'ha5a5a5a5, 1'b0);
    queue_request(OP_ADD,  16'd6400,  16'd0,     32'h1,        1'b0);
    queue_request(OP_ADD,  16'hffff,  16'hffff,  32'h2,        1'b0);
    queue_request(OP_HAS,  16'd6400,  16'd0,     32'h0,        1'b0);
    queue_request(OP_HAS,  16'hffff,  16'd0,     32'h0,        1'b0);
    queue_request(OP_HAS,  16'd6399,  16'd0,     32'h0,        1'b0);
    queue_request(OP_HAS,  16'd100,   16'd0,     32'h0,        1'b0);
    queue_request(OP_FIND, 16'd0,     16'd0,     32'hffffffff, 1'b0);
    queue_request(OP_FIND, 16'd0,     16'd0,     32'ha5a5a5a5, 1'b0);
    queue_request(OP_FIND, 16'd0,     16'd0,     32'h0,        1'b0);
    queue_request(OP_ADD,  16'd500,   16'd0,     32'ha5a5a5a5, 1'b0);
    queue_request(OP_FIND, 16'hffff,  16'hffff,  32'ha5a5a5a5, 1'b0);
    queue_request(OP_LIST, 16'd0,     16'hffff,  32'h0,        1'b0);
    queue_request(OP_LIST, 16'd6399,  16'd0,     32'h0,        1'b0);
    queue_request(OP_LIST, 16'd100,   16'd499,   32'h0,        1'b0);
    queue_request(OP_LIST, 16'd500,   16'd500,   32'h0,        1'b0);
    queue_request(OP_LIST, 16'd6400,  16'hffff,  32'h0,        1'b0);
    queue_request(OP_LIST, 16'd6300,  16'hffff,  32'h0,        1'b0);
    queue_request(OP_ADD,  16'd1234,  16'hffff,  32'h5a5a5a5a, 1'b0);
    wait (accepted_count == queued_count);

    for (int mode = GAPS_NONE; mode <= GAPS_BOTH; mode++) begin
      set_gaps(gap_mode_e'(mode));
      for (int n = 0; n < BATCH; n++) begin
        rq = random_request();
        queue_request(rq.op, rq.meters, rq.meters_to, rq.site, n == 0);
      end
      wait (accepted_count == queued_count);
    end

    // long receiver hold-off while requests keep coming, so the input backs up
    set_gaps(GAPS_NONE);
    hold_kick++;
    for (int n = 0; n < 20; n++) begin
      rq = random_request();
      queue_request(rq.op, rq.meters, rq.meters_to, rq.site, 1'b0);
    end
    wait (accepted_count == queued_count);

    wait (table_answers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bst_pkg.sv
design/bst_cell.sv
design/bst_ring.sv
design/bucketed_slot_table_unit.sv
tb/bucketed_slot_table_unit_test.sv
